[hdl/hrhp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hrhp_pkg;

  typedef enum logic [3:0] {
    PH_METHOD  = 4'd0,
    PH_URL     = 4'd1,
    PH_VERSION = 4'd2,
    PH_VER_LF  = 4'd3,
    PH_NAME    = 4'd4,
    PH_VALUE   = 4'd5,
    PH_VAL_LF  = 4'd6,
    PH_END_LF  = 4'd7,
    PH_DONE    = 4'd8,
    PH_ERROR   = 4'd9
  } phase_e;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BAD   = 8'hFF;

  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [2:0] KIND_METHOD  = 3'd0;
  localparam logic [2:0] KIND_URL     = 3'd1;
  localparam logic [2:0] KIND_VERSION = 3'd2;
  localparam logic [2:0] KIND_NAME    = 3'd3;
  localparam logic [2:0] KIND_VALUE   = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_out;
    logic [2:0] field_kind;
    logic       field_end;
    logic [1:0] parse_status;
  } out_t;

  // Field kind reported for each phase; finished phases report the method kind.
  function automatic logic [2:0] phase_kind(input phase_e ph);
    logic [2:0] k;
    case (ph)
      PH_METHOD:  k = KIND_METHOD;
      PH_URL:     k = KIND_URL;
      PH_VERSION: k = KIND_VERSION;
      PH_VER_LF:  k = KIND_VERSION;
      PH_NAME:    k = KIND_NAME;
      PH_VALUE:   k = KIND_VALUE;
      PH_VAL_LF:  k = KIND_VALUE;
      PH_END_LF:  k = KIND_NAME;
      default:    k = KIND_METHOD;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[hdl/http_request_header_parser_top.sv]
// Each result is registered in the output buffer before it is offered on the output.
// Throughput: one byte per cycle; the parser state update is a single
// registered pass, and a two-entry output buffer keeps input flowing while
// one result waits. Input stalls only when both buffer entries are held.
// Reset (rst_ni low, asynchronous) returns the parser to the method phase
// and empties the output buffer.
`timescale 1ns / 1ps
`default_nettype none

module http_request_header_parser_top #(
  parameter int MAX_FIELD_BYTES = 1023
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire hrhp_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output hrhp_pkg::out_t       out_data_o
);

  logic           take;
  logic           full;
  hrhp_pkg::out_t res;

  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  hrhp_parser #(
    .MaxFieldBytes(MAX_FIELD_BYTES)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (in_data_i),
    .res_o  (res)
  );

  hrhp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[hdl/hrhp_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

module hrhp_parser #(
  parameter int MaxFieldBytes = 1023
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   take_i,
  input  wire hrhp_pkg::in_t    item_i,
  output hrhp_pkg::out_t        res_o
);

  localparam int LenW = $clog2(MaxFieldBytes + 1);
  localparam logic [LenW-1:0] MaxLen = LenW'(MaxFieldBytes);

  hrhp_pkg::phase_e phase_q, phase_d;
  logic             seen_q, seen_d;
  logic [LenW-1:0]  len_q, len_d;

  logic       valid, fend, err, active;
  logic [1:0] status;
  logic [2:0] kind;
  logic [7:0] b;

  assign b      = item_i.data_byte;
  assign active = (phase_q <= hrhp_pkg::PH_END_LF);

  always_comb begin
    phase_d = phase_q;
    seen_d  = seen_q;
    len_d   = len_q;
    valid   = 1'b0;
    fend    = 1'b0;
    err     = 1'b0;
    status  = hrhp_pkg::ST_BUSY;
    kind    = hrhp_pkg::phase_kind(phase_q);

    if (!active) begin
      status = (phase_q == hrhp_pkg::PH_DONE) ? hrhp_pkg::ST_DONE : hrhp_pkg::ST_ERR;
      kind   = hrhp_pkg::KIND_METHOD;
    end else if (item_i.stream_end || b == hrhp_pkg::CH_BAD) begin
      err = 1'b1;
    end else begin
      case (phase_q)
        hrhp_pkg::PH_METHOD, hrhp_pkg::PH_URL: begin
          if (b == hrhp_pkg::CH_SP) begin
            fend    = 1'b1;
            phase_d = (phase_q == hrhp_pkg::PH_METHOD) ? hrhp_pkg::PH_URL
                                                       : hrhp_pkg::PH_VERSION;
            seen_d  = 1'b0;
            len_d   = '0;
          end else if (b == hrhp_pkg::CH_CR || len_q >= MaxLen) begin
            err = 1'b1;
          end else begin
            len_d = len_q + 1'b1;
            valid = 1'b1;
          end
        end
        hrhp_pkg::PH_VERSION: begin
          if (b == hrhp_pkg::CH_CR) begin
            phase_d = hrhp_pkg::PH_VER_LF;
          end else if (len_q >= MaxLen) begin
            err = 1'b1;
          end else begin
            len_d = len_q + 1'b1;
            valid = 1'b1;
          end
        end
        hrhp_pkg::PH_VER_LF, hrhp_pkg::PH_VAL_LF: begin
          if (b != hrhp_pkg::CH_LF) begin
            err = 1'b1;
          end else begin
            fend    = 1'b1;
            phase_d = hrhp_pkg::PH_NAME;
            seen_d  = 1'b0;
            len_d   = '0;
          end
        end
        hrhp_pkg::PH_END_LF: begin
          if (b != hrhp_pkg::CH_LF) begin
            err = 1'b1;
          end else begin
            phase_d = hrhp_pkg::PH_DONE;
            status  = hrhp_pkg::ST_DONE;
          end
        end
        hrhp_pkg::PH_NAME, hrhp_pkg::PH_VALUE: begin
          if (b == hrhp_pkg::CH_CR) begin
            phase_d = (phase_q == hrhp_pkg::PH_NAME) ? hrhp_pkg::PH_END_LF
                                                     : hrhp_pkg::PH_VAL_LF;
          end else if (phase_q == hrhp_pkg::PH_NAME && b == hrhp_pkg::CH_COLON) begin
            fend    = 1'b1;
            phase_d = hrhp_pkg::PH_VALUE;
            seen_d  = 1'b0;
            len_d   = '0;
          end else begin
            // Leading spaces are dropped until the first other byte.
            seen_d = seen_q | (b != hrhp_pkg::CH_SP);
            if (seen_d) begin
              if (len_q >= MaxLen) begin
                err = 1'b1;
              end else begin
                len_d = len_q + 1'b1;
                valid = 1'b1;
              end
            end
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase
    end

    if (err) begin
      phase_d = hrhp_pkg::PH_ERROR;
      status  = hrhp_pkg::ST_ERR;
      valid   = 1'b0;
      fend    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hrhp_pkg::PH_METHOD;
      seen_q  <= 1'b0;
      len_q   <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      seen_q  <= seen_d;
      len_q   <= len_d;
    end
  end

  assign res_o.char_valid   = valid;
  assign res_o.char_out     = valid ? b : 8'h00;
  assign res_o.field_kind   = kind;
  assign res_o.field_end    = fend;
  assign res_o.parse_status = status;

`ifndef NO_ASSERTIONS
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == hrhp_pkg::PH_DONE |=> phase_q == hrhp_pkg::PH_DONE)
    else $error("parser left the done phase");

  a_err_enters_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && res_o.parse_status == hrhp_pkg::ST_ERR |=> phase_q == hrhp_pkg::PH_ERROR)
    else $error("error reported without entering the error phase");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= MaxLen)
    else $error("field length beyond limit");

  a_text_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.char_valid |-> res_o.parse_status == hrhp_pkg::ST_BUSY)
    else $error("text byte passed with a final status");
`endif

endmodule

`default_nettype wire

[hdl/hrhp_out_buf.sv]
`timescale 1ns / 1ps
`default_nettype none

module hrhp_out_buf (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  wire hrhp_pkg::out_t  push_data_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output hrhp_pkg::out_t       out_data_o
);

  // Two entries: the head drives the port, the spare catches a result
  // produced while the head is stalled.
  logic [1:0]     cnt_q, cnt_d;
  hrhp_pkg::out_t head_q, spare_q;
  logic           pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = head_q;

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_q == 2'd2 && pop) begin
      head_q <= spare_q;
    end else if (push_i && (cnt_q == 2'd0 || pop)) begin
      head_q <= push_data_i;
    end
    if (push_i && cnt_q == 2'd1 && !pop) begin
      spare_q <= push_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("buffer count out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q != 2'd2)
    else $error("transfer into a full buffer");

  a_fill_spare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd1 && push_i && !pop |=> cnt_q == 2'd2)
    else $error("spare entry not taken");
`endif

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_FIELD = 1023;

  // The parser latches done or error until reset, so the whole run is one stream.
  typedef enum int {
    END_COMPLETE      = 0,
    END_BAD_BYTE      = 1,
    END_STREAM_CLOSED = 2,
    END_NO_LF_VALUE   = 3,
    END_NO_LF_BLANK   = 4,
    END_OVERLONG      = 5
  } finish_e;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  hrhp_pkg::in_t  in_data = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  hrhp_pkg::out_t out_data;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int sent_count     = 0;
  int checked_count  = 0;
  int fail_count     = 0;
  finish_e end_kind;

  // Tokens predicted for accepted bytes, oldest first.
  hrhp_pkg::out_t token_q[$];

  // Tokenizer state as the block should hold it.
  hrhp_pkg::phase_e tok_phase = hrhp_pkg::PH_METHOD;
  logic   tok_seen  = 1'b0;
  int     tok_len   = 0;

  http_request_header_parser_top #(
    .MAX_FIELD_BYTES(MAX_FIELD)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [2:0] kind_of_phase(input hrhp_pkg::phase_e ph);
    case (ph)
      hrhp_pkg::PH_URL:                        return hrhp_pkg::KIND_URL;
      hrhp_pkg::PH_VERSION, hrhp_pkg::PH_VER_LF: return hrhp_pkg::KIND_VERSION;
      hrhp_pkg::PH_NAME, hrhp_pkg::PH_END_LF:    return hrhp_pkg::KIND_NAME;
      hrhp_pkg::PH_VALUE, hrhp_pkg::PH_VAL_LF:   return hrhp_pkg::KIND_VALUE;
      default:                                 return hrhp_pkg::KIND_METHOD;
    endcase
  endfunction

  function automatic logic store_text_byte();
    if (tok_len >= MAX_FIELD) return 1'b0;
    tok_len++;
    return 1'b1;
  endfunction

  function automatic void open_field(input hrhp_pkg::phase_e ph);
    tok_phase = ph;
    tok_seen  = 1'b0;
    tok_len   = 0;
  endfunction

  function automatic hrhp_pkg::out_t tokenize_byte(input hrhp_pkg::in_t item);
    hrhp_pkg::out_t   r;
    logic             err;
    hrhp_pkg::phase_e ph;
    logic [7:0]       b;
    r   = '0;
    err = 1'b0;
    ph  = tok_phase;
    b   = item.data_byte;
    r.field_kind   = kind_of_phase(ph);
    r.parse_status = hrhp_pkg::ST_BUSY;
    if (ph == hrhp_pkg::PH_DONE) begin
      r.parse_status = hrhp_pkg::ST_DONE;
    end else if (ph == hrhp_pkg::PH_ERROR) begin
      r.parse_status = hrhp_pkg::ST_ERR;
    end else if (item.stream_end || b == hrhp_pkg::CH_BAD) begin
      err = 1'b1;
    end else begin
      case (ph)
        hrhp_pkg::PH_METHOD, hrhp_pkg::PH_URL: begin
          if (b == hrhp_pkg::CH_SP) begin
            r.field_end = 1'b1;
            open_field(ph == hrhp_pkg::PH_METHOD ? hrhp_pkg::PH_URL : hrhp_pkg::PH_VERSION);
          end else if (b == hrhp_pkg::CH_CR || !store_text_byte()) begin
            err = 1'b1;
          end else begin
            r.char_valid = 1'b1;
          end
        end
        hrhp_pkg::PH_VERSION: begin
          if (b == hrhp_pkg::CH_CR) tok_phase = hrhp_pkg::PH_VER_LF;
          else if (!store_text_byte()) err = 1'b1;
          else r.char_valid = 1'b1;
        end
        hrhp_pkg::PH_VER_LF, hrhp_pkg::PH_VAL_LF: begin
          if (b != hrhp_pkg::CH_LF) begin
            err = 1'b1;
          end else begin
            r.field_end = 1'b1;
            open_field(hrhp_pkg::PH_NAME);
          end
        end
        hrhp_pkg::PH_END_LF: begin
          if (b != hrhp_pkg::CH_LF) begin
            err = 1'b1;
          end else begin
            tok_phase      = hrhp_pkg::PH_DONE;
            r.parse_status = hrhp_pkg::ST_DONE;
          end
        end
        hrhp_pkg::PH_NAME, hrhp_pkg::PH_VALUE: begin
          if (b == hrhp_pkg::CH_CR) begin
            tok_phase = (ph == hrhp_pkg::PH_NAME) ? hrhp_pkg::PH_END_LF
                                                  : hrhp_pkg::PH_VAL_LF;
          end else if (ph == hrhp_pkg::PH_NAME && b == hrhp_pkg::CH_COLON) begin
            r.field_end = 1'b1;
            open_field(hrhp_pkg::PH_VALUE);
          end else begin
            if (b != hrhp_pkg::CH_SP) tok_seen = 1'b1;
            if (tok_seen) begin
              if (!store_text_byte()) err = 1'b1;
              else r.char_valid = 1'b1;
            end
          end
        end
        default: err = 1'b1;
      endcase
    end
    if (err) begin
      tok_phase      = hrhp_pkg::PH_ERROR;
      r.parse_status = hrhp_pkg::ST_ERR;
      r.char_valid   = 1'b0;
      r.field_end    = 1'b0;
    end
    if (ph == hrhp_pkg::PH_DONE || ph == hrhp_pkg::PH_ERROR)
      r.field_kind = hrhp_pkg::KIND_METHOD;
    r.char_out = r.char_valid ? b : 8'h00;
    return r;
  endfunction

  // One transfer on the input channel; the token is predicted when it is accepted.
  task automatic send_item(input logic [7:0] b, input logic eos);
    hrhp_pkg::in_t item;
    item.data_byte  = b;
    item.stream_end = eos;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    token_q.push_back(tokenize_byte(item));
    sent_count++;
  endtask

  function automatic logic [7:0] text_byte(input logic in_name);
    logic [7:0] b;
    case ($urandom_range(9))
      0:       b = hrhp_pkg::CH_SP;
      1:       b = hrhp_pkg::CH_LF;
      2:       b = hrhp_pkg::CH_COLON;
      3:       b = 8'hFE;
      default: b = 8'($urandom_range(254));
    endcase
    while (b == hrhp_pkg::CH_CR || (in_name && b == hrhp_pkg::CH_COLON))
      b = 8'($urandom_range(254));
    return b;
  endfunction

  task automatic send_text(input int n, input logic in_name);
    repeat ($urandom_range(2)) send_item(hrhp_pkg::CH_SP, 1'b0);
    repeat (n) send_item(text_byte(in_name), 1'b0);
  endtask

  task automatic send_header(input int name_len, input int value_len);
    send_text(name_len, 1'b1);
    send_item(hrhp_pkg::CH_COLON, 1'b0);
    send_text(value_len, 1'b0);
    send_item(hrhp_pkg::CH_CR, 1'b0);
    send_item(hrhp_pkg::CH_LF, 1'b0);
  endtask

  // A value that starts with a non-space byte, so every byte counts toward its length.
  task automatic send_long_value(input int n);
    send_item(8'h4C, 1'b0);
    send_item(hrhp_pkg::CH_COLON, 1'b0);
    send_item(8'h76, 1'b0);
    repeat (n - 1) send_item(text_byte(1'b0), 1'b0);
  endtask

  task automatic test_request_line();
    // Method with the lowest and highest legal bytes, then an empty URL.
    send_item(8'h00, 1'b0);
    send_item(8'hFE, 1'b0);
    send_item(8'h47, 1'b0);
    send_item(hrhp_pkg::CH_SP, 1'b0);
    send_item(hrhp_pkg::CH_SP, 1'b0);
    send_item(8'h48, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(hrhp_pkg::CH_CR, 1'b0);
    send_item(hrhp_pkg::CH_LF, 1'b0);
  endtask

  task automatic test_directed_headers();
    // Leading spaces are dropped, trailing spaces kept.
    send_item(hrhp_pkg::CH_SP, 1'b0);
    send_item(hrhp_pkg::CH_SP, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(hrhp_pkg::CH_SP, 1'b0);
    send_item(hrhp_pkg::CH_COLON, 1'b0);
    send_item(hrhp_pkg::CH_SP, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(hrhp_pkg::CH_SP, 1'b0);
    send_item(hrhp_pkg::CH_CR, 1'b0);
    send_item(hrhp_pkg::CH_LF, 1'b0);
    // Empty name and empty value.
    send_item(hrhp_pkg::CH_COLON, 1'b0);
    send_item(hrhp_pkg::CH_CR, 1'b0);
    send_item(hrhp_pkg::CH_LF, 1'b0);
    // Colons inside a value are text.
    send_item(8'h6B, 1'b0);
    send_item(hrhp_pkg::CH_COLON, 1'b0);
    send_item(hrhp_pkg::CH_COLON, 1'b0);
    send_item(hrhp_pkg::CH_LF, 1'b0);
    send_item(hrhp_pkg::CH_CR, 1'b0);
    send_item(hrhp_pkg::CH_LF, 1'b0);
  endtask

  task automatic test_random_headers(input int n_bytes);
    int start;
    start = sent_count;
    while (sent_count - start < n_bytes) begin
      if ($urandom_range(9) == 0) send_header($urandom_range(40), $urandom_range(80));
      else send_header($urandom_range(8), $urandom_range(12));
    end
  endtask

  task automatic test_longest_value();
    send_long_value(MAX_FIELD);
    send_item(hrhp_pkg::CH_CR, 1'b0);
    send_item(hrhp_pkg::CH_LF, 1'b0);
  endtask

  task automatic test_termination();
    logic [7:0] b;
    end_kind = finish_e'($urandom_range(5));
    b = 8'($urandom_range(254));
    while (b == hrhp_pkg::CH_LF) b = 8'($urandom_range(254));
    case (end_kind)
      END_COMPLETE: begin
        send_item(hrhp_pkg::CH_CR, 1'b0);
        send_item(hrhp_pkg::CH_LF, 1'b0);
      end
      END_BAD_BYTE: begin
        send_item(8'h4E, 1'b0);
        send_item(hrhp_pkg::CH_BAD, 1'b0);
      end
      END_STREAM_CLOSED: begin
        send_item(8'h4E, 1'b0);
        send_item(8'($urandom_range(255)), 1'b1);
      end
      END_NO_LF_VALUE: begin
        send_item(8'h4B, 1'b0);
        send_item(hrhp_pkg::CH_COLON, 1'b0);
        send_item(8'h76, 1'b0);
        send_item(hrhp_pkg::CH_CR, 1'b0);
        send_item(b, 1'b0);
      end
      END_NO_LF_BLANK: begin
        send_item(hrhp_pkg::CH_CR, 1'b0);
        send_item(b, 1'b0);
      end
      default: send_long_value(MAX_FIELD + 1);
    endcase
  endtask

  // Once finished, the status must hold whatever arrives.
  task automatic test_after_end();
    repeat (30) send_item(8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic compare_token(input hrhp_pkg::out_t want, input hrhp_pkg::out_t got);
    check_field("char_valid", want.char_valid, got.char_valid);
    check_field("char_out", want.char_out, got.char_out);
    check_field("field_kind", want.field_kind, got.field_kind);
    check_field("field_end", want.field_end, got.field_end);
    check_field("parse_status", want.parse_status, got.parse_status);
    checked_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        fail_count++;
        $display("%0t ns: unexpected result, expected none, actual %p", $time, out_data);
      end else begin
        compare_token(token_q.pop_front(), out_data);
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 8;
    recv_stall_pct = 62;
    test_request_line();
    test_directed_headers();
    test_random_headers(130);

    send_idle_pct  = 62;
    recv_stall_pct = 8;
    test_random_headers(130);
    test_longest_value();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_headers(130);
    test_termination();
    test_after_end();

    in_valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Summary: %0d bytes sent and %0d tokens checked; the stream ended by %s.",
             sent_count, checked_count, end_kind.name());
    $display("Covered request line, header lines, a maximal value and the latched status.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
